>>> rtl/core/tppm_pkg.sv
`default_nettype none
package tppm_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TICK_WIDTH_DEF   = 16;
    localparam logic [7:0] WINDOW_RESET = 8'd120;
    localparam int WIN_WIDTH = 8;
    localparam int MEAN_WIDTH = 32;
    localparam int TOTAL_WIDTH = 33;
    localparam int ENERGY_WIDTH = 64;
    localparam int RMS_WIDTH = 16;
endpackage
`default_nettype wire

>>> rtl/core/tppm_if.sv
`default_nettype none
interface tppm_in_if #(
    parameter int SW = tppm_pkg::SAMPLE_WIDTH_DEF,
    parameter int TW = tppm_pkg::TICK_WIDTH_DEF
);
    logic valid;
    logic ready;
    logic signed [SW-1:0] volt_a;
    logic signed [SW-1:0] volt_b;
    logic signed [SW-1:0] volt_c;
    logic signed [SW-1:0] amp_a;
    logic signed [SW-1:0] amp_b;
    logic signed [SW-1:0] amp_c;
    logic [TW-1:0] elapsed_ticks;
    modport source (output valid, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
                    elapsed_ticks, input ready);
    modport sink (input valid, volt_a, volt_b, volt_c, amp_a, amp_b, amp_c,
                  elapsed_ticks, output ready);
endinterface

interface tppm_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] mean_power_a;
    logic signed [31:0] mean_power_b;
    logic signed [31:0] mean_power_c;
    logic signed [32:0] mean_power_total;
    logic signed [63:0] energy_total;
    logic [15:0] rms_volt_a;
    logic [15:0] rms_amp_a;
    modport source (output valid, mean_power_a, mean_power_b, mean_power_c,
                    mean_power_total, energy_total, rms_volt_a, rms_amp_a,
                    input ready);
    modport sink (input valid, mean_power_a, mean_power_b, mean_power_c,
                  mean_power_total, energy_total, rms_volt_a, rms_amp_a,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/three_phase_power_meter_accumulator_unit.sv
`default_nettype none
// Three-phase power meter accumulator. Each input beat carries one group of
// three voltage and three current samples. One shared signed multiplier
// forms the nine products of a group, one per cycle, and adds each into its
// window sum, so a group that does not close a window takes ten
// multiply/retire steps and then passes through idle before the next accept.
// When the group count reaches window_samples (0 acts as 1) the block divides
// the window sums by the group count with one shared restoring divider
// (one quotient bit a cycle, five divisions), forms total * ticks in the
// same multiplier, adds it into the saturating 64-bit energy store, and
// takes two bit-pair square roots of 19 steps each. The next accept after a
// closing group waits until the result beat is loaded into the output
// register, so a stalled result beat holds it off. The result beat sits in
// the output register while the next input beat is accepted. Means truncate
// toward zero. The user must write window_samples through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce it.
module three_phase_power_meter_accumulator_unit #(
    parameter int SAMPLE_WIDTH = tppm_pkg::SAMPLE_WIDTH_DEF,
    parameter int TICK_WIDTH   = tppm_pkg::TICK_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [tppm_pkg::WIN_WIDTH-1:0] cfg_wdata,
    tppm_in_if.sink  in_ch,
    tppm_out_if.source out_ch
);
    localparam int SQW = 2*SAMPLE_WIDTH + 6;   // square sum width
    localparam int PWW = 2*SAMPLE_WIDTH + 7;   // power sum width
    localparam int DW  = PWW;                  // dividend magnitude width
    localparam int DCW = $clog2(DW+1);
    localparam int RW  = SQW/2 + 1;            // sqrt root width
    localparam int SIT = SQW/2;                // sqrt steps, two radicand bits each
    localparam int RCW = $clog2(SIT+1);
    localparam int OPW = (TICK_WIDTH+1 > 36) ? TICK_WIDTH+1 : 36; // mult operand
    localparam int EW  = tppm_pkg::ENERGY_WIDTH;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAC   = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_EMUL  = 8'b0000_1000,
        S_EADD  = 8'b0001_0000,
        S_SQRT  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_CLR   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] win_reg;
    logic [7:0] count_reg;
    logic [SQW-1:0] vsq_reg [3];
    logic [SQW-1:0] asq_reg [3];
    logic signed [PWW-1:0] pw_reg [3];
    logic signed [EW-1:0] energy_reg;

    // captured input beat
    logic signed [SAMPLE_WIDTH-1:0] v_reg [3];
    logic signed [SAMPLE_WIDTH-1:0] a_reg [3];
    logic [TICK_WIDTH-1:0] ticks_reg;

    logic [3:0] step_reg;        // mac step / division index / sqrt index
    logic [8:0] groups_reg;      // groups in the closing window

    // shared multiplier operands, registered product
    logic signed [OPW-1:0] mul_x, mul_y;
    logic signed [2*OPW-1:0] prod_reg;
    logic prod_vld_reg;
    logic [3:0] prod_tag_reg;

    // divider
    logic [DW-1:0] dq_reg;       // dividend shifting into quotient
    logic [8:0] drem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic dneg_reg;
    logic [DW-1:0] quot_reg [5]; // quotient magnitudes (0..2 power, 3 vsq, 4 asq)
    logic qneg_reg [3];

    // sqrt
    logic [SQW-1:0] sx_reg;
    logic [RW+1:0] sr_reg;       // root so far
    logic [RW+2:0] srem_reg;
    logic [RCW-1:0] scnt_reg;
    logic [RW-1:0] root_reg [2];

    logic signed [tppm_pkg::MEAN_WIDTH-1:0] mean_reg [3];
    logic signed [tppm_pkg::TOTAL_WIDTH-1:0] total_reg;

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    logic [7:0] window_eff;
    assign window_eff = (win_reg == 8'd0) ? 8'd1 : win_reg;

    // multiplier operand select: steps 0..8 are the group products
    always_comb
    begin
        logic [1:0] ph;
        priority if (step_reg < 4'd3)
            ph = 2'(step_reg);
        else if (step_reg < 4'd6)
            ph = 2'(step_reg - 4'd3);
        else if (step_reg < 4'd9)
            ph = 2'(step_reg - 4'd6);
        else
            ph = 2'd0;
        mul_x = '0;
        mul_y = '0;
        if (state_reg == S_MAC)
        begin
            priority if (step_reg < 4'd3)
            begin
                mul_x = OPW'(v_reg[ph]);
                mul_y = OPW'(v_reg[ph]);
            end
            else if (step_reg < 4'd6)
            begin
                mul_x = OPW'(a_reg[ph]);
                mul_y = OPW'(a_reg[ph]);
            end
            else
            begin
                mul_x = OPW'(v_reg[ph]);
                mul_y = OPW'(a_reg[ph]);
            end
        end
        else
        begin
            mul_x = OPW'(total_reg);
            mul_y = OPW'({1'b0, ticks_reg});
        end
    end

    // energy saturating add
    logic signed [EW:0] esum;
    logic signed [EW-1:0] esat;
    always_comb
    begin
        esum = {energy_reg[EW-1], energy_reg} + (EW+1)'(prod_reg);
        if (esum[EW] != esum[EW-1])
            esat = esum[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        else
            esat = esum[EW-1:0];
    end

    // divider step
    logic [9:0] dtrial;
    assign dtrial = {drem_reg, dq_reg[DW-1]} - {1'b0, groups_reg};

    // sqrt step (two bits of the radicand per cycle)
    logic [RW+2:0] strial;
    logic [RW+2:0] sshift;
    logic [SQW+1:0] sxp;
    assign sxp = {2'b00, sx_reg};
    assign sshift = {srem_reg[RW:0], sxp[SQW-1 -: 2]};
    assign strial = sshift - {sr_reg[RW:0], 2'b01};

    function automatic logic [DW-1:0] mag_of(input logic signed [PWW-1:0] x);
        return x[PWW-1] ? DW'(-x) : DW'(x);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_MAC;
            S_MAC:
                if (step_reg == 4'd9)
                    state_next = ({1'b0, count_reg} + 9'd1 >= {1'b0, window_eff})
                                 ? S_DIV : S_IDLE;
            S_DIV:
                if (dcnt_reg == DCW'(DW) && step_reg == 4'd4) state_next = S_EMUL;
            S_EMUL: state_next = S_EADD;
            S_EADD: state_next = S_SQRT;
            S_SQRT:
                if (scnt_reg == RCW'(SIT) && step_reg == 4'd1) state_next = S_OUT;
            S_OUT: if (!out_ch.valid || out_fire) state_next = S_CLR;
            S_CLR: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            win_reg <= tppm_pkg::WINDOW_RESET;
            count_reg <= '0;
            energy_reg <= '0;
            step_reg <= '0;
            prod_vld_reg <= 1'b0;
            out_ch.valid <= 1'b0;
            for (int p = 0; p < 3; p++)
            begin
                vsq_reg[p] <= '0;
                asq_reg[p] <= '0;
                pw_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) win_reg <= cfg_wdata;
            // result beat loads in S_OUT, drops when taken
            if (state_reg == S_OUT && (!out_ch.valid || out_fire))
                out_ch.valid <= 1'b1;
            else if (out_fire)
                out_ch.valid <= 1'b0;
            prod_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    step_reg <= '0;
                S_MAC:
                begin
                    // issue product for step, retire previous one
                    prod_reg <= mul_x * mul_y;
                    prod_vld_reg <= (step_reg < 4'd9);
                    prod_tag_reg <= step_reg;
                    if (prod_vld_reg)
                    begin
                        priority if (prod_tag_reg < 4'd3)
                            vsq_reg[2'(prod_tag_reg)] <= vsq_reg[2'(prod_tag_reg)]
                                                         + SQW'(prod_reg);
                        else if (prod_tag_reg < 4'd6)
                            asq_reg[2'(prod_tag_reg - 4'd3)] <=
                                asq_reg[2'(prod_tag_reg - 4'd3)] + SQW'(prod_reg);
                        else
                            pw_reg[2'(prod_tag_reg - 4'd6)] <=
                                pw_reg[2'(prod_tag_reg - 4'd6)] + PWW'(prod_reg);
                    end
                    if (step_reg == 4'd9)
                    begin
                        step_reg <= '0;
                        groups_reg <= {1'b0, count_reg} + 9'd1;
                        count_reg <= count_reg + 8'd1;
                        dcnt_reg <= '0;
                        drem_reg <= '0;
                        dq_reg <= mag_of(pw_reg[0]);
                        dneg_reg <= pw_reg[0][PWW-1];
                    end
                    else
                        step_reg <= step_reg + 4'd1;
                end
                S_DIV:
                begin
                    if (dcnt_reg != DCW'(DW))
                    begin
                        dcnt_reg <= dcnt_reg + DCW'(1);
                        if (!dtrial[9])
                        begin
                            drem_reg <= dtrial[8:0];
                            dq_reg <= {dq_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[7:0], dq_reg[DW-1]};
                            dq_reg <= {dq_reg[DW-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        quot_reg[3'(step_reg)] <= dq_reg;
                        if (step_reg < 4'd3) qneg_reg[2'(step_reg)] <= dneg_reg;
                        dcnt_reg <= '0;
                        drem_reg <= '0;
                        dneg_reg <= 1'b0;
                        priority if (step_reg < 4'd2)
                        begin
                            dq_reg <= mag_of(pw_reg[2'(step_reg + 4'd1)]);
                            dneg_reg <= pw_reg[2'(step_reg + 4'd1)][PWW-1];
                        end
                        else if (step_reg == 4'd2)
                            dq_reg <= DW'(vsq_reg[0]);
                        else
                            dq_reg <= DW'(asq_reg[0]);
                        step_reg <= (step_reg == 4'd4) ? 4'd0 : step_reg + 4'd1;
                        if (step_reg == 4'd2)
                        begin
                            for (int p = 0; p < 3; p++)
                                mean_reg[p] <= (p == 2)
                                    ? (dneg_reg ? -32'(dq_reg) : 32'(dq_reg))
                                    : (qneg_reg[p] ? -32'(quot_reg[p])
                                                   : 32'(quot_reg[p]));
                        end
                    end
                end
                S_EMUL:
                begin
                    count_reg <= '0;
                    prod_reg <= mul_x * mul_y;
                end
                S_EADD:
                begin
                    energy_reg <= esat;
                    sx_reg <= SQW'(quot_reg[3]);
                    sr_reg <= '0;
                    srem_reg <= '0;
                    scnt_reg <= '0;
                    step_reg <= '0;
                end
                S_SQRT:
                begin
                    if (scnt_reg != RCW'(SIT))
                    begin
                        scnt_reg <= scnt_reg + RCW'(1);
                        sx_reg <= {sx_reg[SQW-3:0], 2'b00};
                        if (!strial[RW+2])
                        begin
                            srem_reg <= strial;
                            sr_reg <= {sr_reg[RW:0], 1'b1};
                        end
                        else
                        begin
                            srem_reg <= sshift;
                            sr_reg <= {sr_reg[RW:0], 1'b0};
                        end
                    end
                    else
                    begin
                        root_reg[1'(step_reg)] <= sr_reg[RW-1:0];
                        sx_reg <= SQW'(quot_reg[4]);
                        sr_reg <= '0;
                        srem_reg <= '0;
                        scnt_reg <= '0;
                        step_reg <= step_reg + 4'd1;
                    end
                end
                S_OUT:
                begin
                    if (!out_ch.valid || out_fire)
                    begin
                        out_ch.mean_power_a <= mean_reg[0];
                        out_ch.mean_power_b <= mean_reg[1];
                        out_ch.mean_power_c <= mean_reg[2];
                        out_ch.mean_power_total <= total_reg;
                        out_ch.energy_total <= energy_reg;
                        out_ch.rms_volt_a <= 16'(root_reg[0]);
                        out_ch.rms_amp_a <= 16'(root_reg[1]);
                    end
                end
                S_CLR:
                begin
                    for (int p = 0; p < 3; p++)
                    begin
                        vsq_reg[p] <= '0;
                        asq_reg[p] <= '0;
                        pw_reg[p] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // total of the three means, formed once the means settle
    always_ff @(posedge clk)
    begin
        total_reg <= 33'(mean_reg[0]) + 33'(mean_reg[1]) + 33'(mean_reg[2]);
    end

    // capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            v_reg[0] <= in_ch.volt_a;
            v_reg[1] <= in_ch.volt_b;
            v_reg[2] <= in_ch.volt_c;
            a_reg[0] <= in_ch.amp_a;
            a_reg[1] <= in_ch.amp_b;
            a_reg[2] <= in_ch.amp_c;
            ticks_reg <= in_ch.elapsed_ticks;
        end
    end

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.energy_total))
        else $error("result changed while stalled");
    a_count_win: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> {1'b0, count_reg} < 9'd256)
        else $error("count overflow");
endmodule
`default_nettype wire

>>> dv/tppm_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module tppm_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    tppm_in_if.sink         in_mon,
    tppm_out_if.sink        out_mon,
    output int              fail_count,
    output int              pending_windows
);
    typedef struct {
        logic signed [31:0] mean_a;
        logic signed [31:0] mean_b;
        logic signed [31:0] mean_c;
        logic signed [32:0] mean_total;
        logic signed [63:0] energy;
        logic [15:0]        rms_v;
        logic [15:0]        rms_a;
    } meter_result_t;

    meter_result_t window_results_q[$];

    // predictor state
    logic [7:0]         win_setting;
    logic [7:0]         groups_seen;
    longint unsigned    vsq_sum[3];
    longint unsigned    asq_sum[3];
    longint             pwr_sum[3];
    logic signed [63:0] energy_acc;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    task automatic accumulate_group();
        longint v[3];
        longint a[3];
        longint unsigned groups;
        longint unsigned win;
        longint mean[3];
        longint total;
        longint unsigned mag;
        longint unsigned prod;
        logic [63:0] u;
        meter_result_t r;
        v[0] = in_mon.volt_a; v[1] = in_mon.volt_b; v[2] = in_mon.volt_c;
        a[0] = in_mon.amp_a;  a[1] = in_mon.amp_b;  a[2] = in_mon.amp_c;
        for (int p = 0; p < 3; p++)
        begin
            vsq_sum[p] += longint'(v[p] * v[p]);
            asq_sum[p] += longint'(a[p] * a[p]);
            pwr_sum[p] += v[p] * a[p];
        end
        groups = groups_seen + 1;
        win = (win_setting == 0) ? 1 : win_setting;
        if (groups < win)
        begin
            groups_seen = groups[7:0];
            return;
        end
        total = 0;
        for (int p = 0; p < 3; p++)
        begin
            mean[p] = pwr_sum[p] / longint'(groups);
            total += mean[p];
        end
        // saturating energy add in biased form
        u = energy_acc ^ (64'd1 << 63);
        mag = (total < 0) ? -total : total;
        prod = mag * longint'(in_mon.elapsed_ticks);
        if (total >= 0)
            u = (prod > ~u) ? '1 : u + prod;
        else
            u = (prod > u) ? '0 : u - prod;
        energy_acc = u ^ (64'd1 << 63);
        r.mean_a = mean[0][31:0];
        r.mean_b = mean[1][31:0];
        r.mean_c = mean[2][31:0];
        r.mean_total = total[32:0];
        r.energy = energy_acc;
        r.rms_v = isqrt(vsq_sum[0] / groups);
        r.rms_a = isqrt(asq_sum[0] / groups);
        window_results_q.push_back(r);
        for (int p = 0; p < 3; p++)
        begin
            vsq_sum[p] = 0; asq_sum[p] = 0; pwr_sum[p] = 0;
        end
        groups_seen = 0;
    endtask

    task automatic compare_result();
        meter_result_t e;
        if (window_results_q.size() == 0)
        begin
            report_mismatch("unexpected result beat", 0, 0);
            return;
        end
        e = window_results_q.pop_front();
        if (out_mon.mean_power_a !== e.mean_a)
            report_mismatch("mean_power_a", 64'(out_mon.mean_power_a), 64'(e.mean_a));
        if (out_mon.mean_power_b !== e.mean_b)
            report_mismatch("mean_power_b", 64'(out_mon.mean_power_b), 64'(e.mean_b));
        if (out_mon.mean_power_c !== e.mean_c)
            report_mismatch("mean_power_c", 64'(out_mon.mean_power_c), 64'(e.mean_c));
        if (out_mon.mean_power_total !== e.mean_total)
            report_mismatch("mean_power_total", 64'(out_mon.mean_power_total),
                            64'(e.mean_total));
        if (out_mon.energy_total !== e.energy)
            report_mismatch("energy_total", out_mon.energy_total, e.energy);
        if (out_mon.rms_volt_a !== e.rms_v)
            report_mismatch("rms_volt_a", 64'(out_mon.rms_volt_a), 64'(e.rms_v));
        if (out_mon.rms_amp_a !== e.rms_a)
            report_mismatch("rms_amp_a", 64'(out_mon.rms_amp_a), 64'(e.rms_a));
    endtask

    assign pending_windows = window_results_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_setting = tppm_pkg::WINDOW_RESET;
            groups_seen = 0;
            energy_acc = 0;
            for (int p = 0; p < 3; p++)
            begin
                vsq_sum[p] = 0; asq_sum[p] = 0; pwr_sum[p] = 0;
            end
            window_results_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                compare_result();
            if (in_mon.valid && in_mon.ready)
                accumulate_group();
            if (cfg_we)
                win_setting = cfg_wdata;
        end
    end
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int IDLE_LIMIT = 20000;  // idle watchdog limit in cycles

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         fail_count;
    int         pending_windows;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_recv;
    bit         hold_request;
    int         idle_cycles;
    bit         timed_out;

    tppm_in_if  in_ch ();
    tppm_out_if out_ch ();

    three_phase_power_meter_accumulator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    tppm_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_mon         (in_ch.sink),
        .out_mon        (out_ch.sink),
        .fail_count     (fail_count),
        .pending_windows(pending_windows)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off counted here when asked
    always @(negedge clk)
    begin
        if (hold_request && !hold_recv)
        begin
            hold_recv = 1'b1;
            out_ch.ready <= 1'b0;
            repeat (2000) @(negedge clk);
            hold_recv = 1'b0;
            hold_request = 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: counts cycles in which no beat moves on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Test completed with failures");
            $finish;
        end
    end

    // drive one sample group and hold it until the beat is taken
    task automatic send_group(input logic [15:0] va, vb, vc, aa, ab, ac, ticks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.volt_a = va; in_ch.volt_b = vb; in_ch.volt_c = vc;
        in_ch.amp_a = aa;  in_ch.amp_b = ab;  in_ch.amp_c = ac;
        in_ch.elapsed_ticks = ticks;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic send_random_group();
        logic [15:0] s[6];
        for (int k = 0; k < 6; k++)
        begin
            case ($urandom_range(5))
                0: s[k] = 16'h8000;
                1: s[k] = 16'h7fff;
                2: s[k] = 16'($urandom_range(15)) - 16'd8;
                default: s[k] = 16'($urandom);
            endcase
        end
        send_group(s[0], s[1], s[2], s[3], s[4], s[5],
                   ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom));
    endtask

    // idle-only config write: wait for all results, then let the block finish
    task automatic write_window(input logic [7:0] w);
        while (pending_windows != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.volt_a = '0; in_ch.volt_b = '0; in_ch.volt_c = '0;
        in_ch.amp_a = '0;  in_ch.amp_b = '0;  in_ch.amp_c = '0;
        in_ch.elapsed_ticks = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 1'b0;
        hold_request = 1'b0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: window of one, field extremes and sign corners
        write_window(8'd1);
        send_group(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        send_group(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        send_group(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_group(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'h0001);
        // window of zero behaves as one
        write_window(8'd0);
        send_group(16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h8000);
        send_group(16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 16'hffff, 16'h00ff);
        // truncation toward zero with a window of three
        write_window(8'd3);
        send_group(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 16'h0000);
        send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_group(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0007);
        // window lowered mid-window: two groups in, then window of one
        write_window(8'd5);
        send_group(16'h4000, 16'hc000, 16'h2000, 16'h4000, 16'h4000, 16'he000, 16'h0000);
        send_group(16'h3000, 16'hd000, 16'h1000, 16'h3000, 16'h3000, 16'hf000, 16'h0000);
        write_window(8'd1);
        send_group(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1111);

        // random phases; long windows are rare to keep the run short
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 11 : 0;
            for (int seg = 0; seg < 6; seg++)
            begin
                case (seg)
                    0: write_window(8'd1);
                    1: write_window(8'd255);
                    2: write_window(8'($urandom_range(4, 1)));
                    3: write_window(8'd2);
                    4: write_window(8'($urandom_range(16, 1)));
                    default: write_window(tppm_pkg::WINDOW_RESET);
                endcase
                if (phase == 0 && seg == 0)
                    hold_request = 1'b1;  // long receiver hold-off while sending
                for (int n = 0; n < ((seg == 1) ? 255 : (seg == 5) ? 120 : 20); n++)
                    send_random_group();
                if (seg == 2)
                begin
                    // sender pause until every result has drained
                    while (pending_windows != 0)
                        @(negedge clk);
                end
            end
        end

        while (pending_windows != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
